### hdl/ray_triangle_intersect_unit_assert.svh
// assertion macros for the ray / triangle intersection unit
// no dependencies; taken in by the top level with an include
`ifndef RAY_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define RTI_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RTI_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rti_pkg.sv
// shared constants and codes for the ray / triangle intersection unit
// no dependencies
package rti_pkg;

  // default coordinate format, signed q16.16
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // operand slice width of the pipelined multipliers
  localparam int MUL_CHUNK = 32;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_DIR_X = 2'd0,
    REG_DIR_Y = 2'd1,
    REG_DIR_Z = 2'd2
  } reg_idx_t;

endpackage

### hdl/ray_triangle_intersect_unit.sv
// ray / triangle intersection unit: bounding box reject, moller-trumbore test, hit point
// one word accepted per cycle while the output is not stalled
// the depth is set by the three multiplier banks and the bit-per-stage floor divider
// a stall at the output holds every stage; rst_n (synchronous) clears all valid bits
// reset sets direction to (0, 0, 1.0); depends on rti_pkg, rti_mul, rti_div
`include "ray_triangle_intersect_unit_assert.svh"

module ray_triangle_intersect_unit #(
  parameter int COORD_WIDTH = rti_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rti_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_WIDTH-1:0]  in_origin_x,
  input  logic signed [COORD_WIDTH-1:0]  in_origin_y,
  input  logic signed [COORD_WIDTH-1:0]  in_origin_z,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex0_x,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex0_y,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex0_z,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex1_x,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex1_y,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex1_z,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex2_x,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex2_y,
  input  logic signed [COORD_WIDTH-1:0]  in_vertex2_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic signed [COORD_WIDTH-1:0]  out_point_x,
  output logic signed [COORD_WIDTH-1:0]  out_point_y,
  output logic signed [COORD_WIDTH-1:0]  out_point_z,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [((COORD_WIDTH > 32) ? 3 : 2)+1:0] paddr,
  input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] prdata,
  output logic                           pready
);
  import rti_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int E   = W + 1;
  localparam int CW  = 2 * E + 1;
  localparam int DW  = E + CW + 2;
  localparam int NW  = W + DW;
  localparam int QB  = W + 2;
  localparam int QW  = QB + 2;
  localparam int SW  = QW + 1;
  localparam int ASH = (W > 32) ? 3 : 2;
  localparam int PAW = ASH + 2;
  localparam int PDW = (W > 32) ? 64 : 32;
  localparam logic signed [SW-1:0] PMAX = $signed((SW'(1) << (W - 1)) - SW'(1));
  localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);

  typedef struct packed {
    logic              v;
    logic              box;
    logic [2:0][W-1:0] o;
  } base_t;

  typedef struct packed {
    base_t             b;
    logic [2:0][E-1:0] e1;
    logic [2:0][E-1:0] e2;
    logic [2:0][E-1:0] s;
  } st1_t;

  typedef struct packed {
    base_t              b;
    logic [2:0][E-1:0]  e1;
    logic [2:0][E-1:0]  e2;
    logic [2:0][E-1:0]  s;
    logic [2:0][CW-1:0] h;
    logic [2:0][CW-1:0] q;
  } st2_t;

  typedef struct packed {
    base_t         b;
    logic [DW-1:0] a;
    logic [DW-1:0] u;
    logic [DW-1:0] vv;
    logic [DW-1:0] t;
  } st3_t;

  typedef struct packed {
    logic              v;
    logic              ok;
    logic [2:0][W-1:0] o;
    logic [DW-1:0]     a;
    logic [DW-1:0]     t;
  } st5_t;

  typedef struct packed {
    logic              v;
    logic              ok;
    logic [2:0][W-1:0] o;
    logic [DW-1:0]     a;
  } tag3_t;

  typedef struct packed {
    logic              v;
    logic              ok;
    logic [2:0][W-1:0] o;
  } tag4_t;

  // inclusive span test of p against three signed values
  function automatic logic in_span(input logic signed [W-1:0] p, input logic signed [W-1:0] a,
                                   input logic signed [W-1:0] b, input logic signed [W-1:0] c);
    logic signed [W-1:0] lo;
    logic signed [W-1:0] hi;
    lo = (b < a) ? b : a;
    hi = (b > a) ? b : a;
    lo = (c < lo) ? c : lo;
    hi = (c > hi) ? c : hi;
    return (p >= lo) && (p <= hi);
  endfunction

  logic signed [W-1:0] dir_x_r, dir_y_r, dir_z_r;
  logic [1:0]          reg_idx;
  logic                en;

  st1_t  c1_nxt, c1_r;
  st2_t  c2_nxt, c2_r;
  st3_t  c3_nxt, c3_r;
  st3_t  c4_nxt, c4_r;
  st5_t  c5_nxt, c5_r;
  st1_t  t1o;
  base_t t2o;
  tag3_t t3o;
  tag4_t t4o;
  logic [$bits(st1_t)-1:0]  t1o_v;
  logic [$bits(base_t)-1:0] t2o_v;
  logic [$bits(tag3_t)-1:0] t3o_v;
  logic [$bits(tag4_t)-1:0] t4o_v;

  logic signed [E-1:0]    m1a [12];
  logic signed [E-1:0]    m1b [12];
  logic signed [2*E-1:0]  p1  [12];
  logic signed [E-1:0]    m2a [12];
  logic signed [CW-1:0]   m2b [12];
  logic signed [E+CW-1:0] p2  [12];
  logic signed [W-1:0]    m3a [3];
  logic signed [NW-1:0]   p3  [3];
  logic signed [QW-1:0]   qd  [3];

  logic                        out_valid_r, hit_r;
  logic [2:0][W-1:0]           pt_r;
  logic [2:0][W-1:0]           pt_nxt;

  // configuration port
  assign reg_idx = paddr[PAW-1:ASH];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_x_r <= '0;
      dir_y_r <= '0;
      dir_z_r <= W'(64'(1) << FRAC_BITS);
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(reg_idx))
        REG_DIR_X: dir_x_r <= pwdata[W-1:0];
        REG_DIR_Y: dir_y_r <= pwdata[W-1:0];
        REG_DIR_Z: dir_z_r <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(reg_idx))
      REG_DIR_X: prdata = PDW'(unsigned'(dir_x_r));
      REG_DIR_Y: prdata = PDW'(unsigned'(dir_y_r));
      REG_DIR_Z: prdata = PDW'(unsigned'(dir_z_r));
      default:   prdata = '0;
    endcase
  end

  // global advance: everything moves unless a finished word is held
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // stage 1: edges, origin offset, bounding box
  always_comb begin
    c1_nxt.b.v   = in_valid;
    c1_nxt.b.box = in_span(in_origin_x, in_vertex0_x, in_vertex1_x, in_vertex2_x) &&
                   in_span(in_origin_y, in_vertex0_y, in_vertex1_y, in_vertex2_y);
    c1_nxt.b.o[0] = in_origin_x;
    c1_nxt.b.o[1] = in_origin_y;
    c1_nxt.b.o[2] = in_origin_z;
    c1_nxt.e1[0] = E'(in_vertex1_x) - E'(in_vertex0_x);
    c1_nxt.e1[1] = E'(in_vertex1_y) - E'(in_vertex0_y);
    c1_nxt.e1[2] = E'(in_vertex1_z) - E'(in_vertex0_z);
    c1_nxt.e2[0] = E'(in_vertex2_x) - E'(in_vertex0_x);
    c1_nxt.e2[1] = E'(in_vertex2_y) - E'(in_vertex0_y);
    c1_nxt.e2[2] = E'(in_vertex2_z) - E'(in_vertex0_z);
    c1_nxt.s[0]  = E'(in_origin_x) - E'(in_vertex0_x);
    c1_nxt.s[1]  = E'(in_origin_y) - E'(in_vertex0_y);
    c1_nxt.s[2]  = E'(in_origin_z) - E'(in_vertex0_z);
  end

  // bank 1 operands: h = dir x e2, q = s x e1
  always_comb begin
    m1a[0]  = E'(dir_y_r);     m1b[0]  = c1_r.e2[2];
    m1a[1]  = E'(dir_z_r);     m1b[1]  = c1_r.e2[1];
    m1a[2]  = E'(dir_z_r);     m1b[2]  = c1_r.e2[0];
    m1a[3]  = E'(dir_x_r);     m1b[3]  = c1_r.e2[2];
    m1a[4]  = E'(dir_x_r);     m1b[4]  = c1_r.e2[1];
    m1a[5]  = E'(dir_y_r);     m1b[5]  = c1_r.e2[0];
    m1a[6]  = c1_r.s[1];       m1b[6]  = c1_r.e1[2];
    m1a[7]  = c1_r.s[2];       m1b[7]  = c1_r.e1[1];
    m1a[8]  = c1_r.s[2];       m1b[8]  = c1_r.e1[0];
    m1a[9]  = c1_r.s[0];       m1b[9]  = c1_r.e1[2];
    m1a[10] = c1_r.s[0];       m1b[10] = c1_r.e1[1];
    m1a[11] = c1_r.s[1];       m1b[11] = c1_r.e1[0];
  end

  for (genvar k = 0; k < 12; k++) begin : g_m1
    if (k == 0) begin : g_tag
      rti_mul #(.AW(E), .BW(E), .TW($bits(st1_t))) u_mul (
        .clk(clk), .rst_n(rst_n), .en(en), .a(m1a[k]), .b(m1b[k]),
        .tag_i(c1_r), .p(p1[k]), .tag_o(t1o_v));
    end else begin : g_plain
      rti_mul #(.AW(E), .BW(E), .TW(1)) u_mul (
        .clk(clk), .rst_n(rst_n), .en(en), .a(m1a[k]), .b(m1b[k]),
        .tag_i(1'b0), .p(p1[k]), .tag_o());
    end
  end
  assign t1o = st1_t'(t1o_v);

  // stage 2: cross product differences
  always_comb begin
    c2_nxt.b  = t1o.b;
    c2_nxt.e1 = t1o.e1;
    c2_nxt.e2 = t1o.e2;
    c2_nxt.s  = t1o.s;
    for (int i = 0; i < 3; i++) begin
      c2_nxt.h[i] = CW'(p1[2*i]) - CW'(p1[2*i+1]);
      c2_nxt.q[i] = CW'(p1[6+2*i]) - CW'(p1[7+2*i]);
    end
  end

  // bank 2 operands: a = e1.h, u = s.h, v = dir.q, t = e2.q
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m2a[i]   = c2_r.e1[i];  m2b[i]   = c2_r.h[i];
      m2a[3+i] = c2_r.s[i];   m2b[3+i] = c2_r.h[i];
      m2a[9+i] = c2_r.e2[i];  m2b[9+i] = c2_r.q[i];
      m2b[6+i] = c2_r.q[i];
    end
    m2a[6] = E'(dir_x_r);
    m2a[7] = E'(dir_y_r);
    m2a[8] = E'(dir_z_r);
  end

  for (genvar k = 0; k < 12; k++) begin : g_m2
    if (k == 0) begin : g_tag
      rti_mul #(.AW(E), .BW(CW), .TW($bits(base_t))) u_mul (
        .clk(clk), .rst_n(rst_n), .en(en), .a(m2a[k]), .b(m2b[k]),
        .tag_i(c2_r.b), .p(p2[k]), .tag_o(t2o_v));
    end else begin : g_plain
      rti_mul #(.AW(E), .BW(CW), .TW(1)) u_mul (
        .clk(clk), .rst_n(rst_n), .en(en), .a(m2a[k]), .b(m2b[k]),
        .tag_i(1'b0), .p(p2[k]), .tag_o());
    end
  end
  assign t2o = base_t'(t2o_v);

  // stage 3: dot product sums
  always_comb begin
    c3_nxt.b  = t2o;
    c3_nxt.a  = DW'(p2[0]) + DW'(p2[1]) + DW'(p2[2]);
    c3_nxt.u  = DW'(p2[3]) + DW'(p2[4]) + DW'(p2[5]);
    c3_nxt.vv = DW'(p2[6]) + DW'(p2[7]) + DW'(p2[8]);
    c3_nxt.t  = DW'(p2[9]) + DW'(p2[10]) + DW'(p2[11]);
  end

  // stage 4: make the determinant non-negative
  always_comb begin
    c4_nxt = c3_r;
    if (c3_r.a[DW-1]) begin
      c4_nxt.a  = -c3_r.a;
      c4_nxt.u  = -c3_r.u;
      c4_nxt.vv = -c3_r.vv;
      c4_nxt.t  = -c3_r.t;
    end
  end

  // stage 5: barycentric and distance range checks
  always_comb begin
    logic signed [DW:0]   amu;
    logic signed [DW+1:0] amuv;
    amu  = (DW+1)'($signed(c4_r.a)) - (DW+1)'($signed(c4_r.u));
    amuv = (DW+2)'($signed(c4_r.a)) - (DW+2)'($signed(c4_r.u)) - (DW+2)'($signed(c4_r.vv));
    c5_nxt.v  = c4_r.b.v;
    c5_nxt.o  = c4_r.b.o;
    c5_nxt.a  = c4_r.a;
    c5_nxt.t  = c4_r.t;
    c5_nxt.ok = c4_r.b.box && (c4_r.a != '0) && !c4_r.u[DW-1] && !amu[DW] &&
                !c4_r.vv[DW-1] && !amuv[DW+1] && !c4_r.t[DW-1] && (c4_r.t != '0);
  end

  // bank 3: dir * t
  assign m3a[0] = dir_x_r;
  assign m3a[1] = dir_y_r;
  assign m3a[2] = dir_z_r;

  for (genvar k = 0; k < 3; k++) begin : g_m3
    if (k == 0) begin : g_tag
      rti_mul #(.AW(W), .BW(DW), .TW($bits(tag3_t))) u_mul (
        .clk(clk), .rst_n(rst_n), .en(en), .a(m3a[k]), .b(c5_r.t), .p(p3[k]),
        .tag_i({c5_r.v, c5_r.ok, c5_r.o, c5_r.a}), .tag_o(t3o_v));
    end else begin : g_plain
      rti_mul #(.AW(W), .BW(DW), .TW(1)) u_mul (
        .clk(clk), .rst_n(rst_n), .en(en), .a(m3a[k]), .b(c5_r.t), .p(p3[k]),
        .tag_i(1'b0), .tag_o());
    end
  end
  assign t3o = tag3_t'(t3o_v);

  // floor division by the determinant
  for (genvar k = 0; k < 3; k++) begin : g_dv
    if (k == 0) begin : g_tag
      rti_div #(.NW(NW), .DW(DW), .QB(QB), .TW($bits(tag4_t))) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .n(p3[k]), .d(t3o.a),
        .tag_i({t3o.v, t3o.ok, t3o.o}), .q(qd[k]), .tag_o(t4o_v));
    end else begin : g_plain
      rti_div #(.NW(NW), .DW(DW), .QB(QB), .TW(1)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en), .n(p3[k]), .d(t3o.a),
        .tag_i(1'b0), .q(qd[k]), .tag_o());
    end
  end
  assign t4o = tag4_t'(t4o_v);

  // origin plus offset, saturated, zero on a miss
  always_comb begin
    logic signed [SW-1:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum = SW'($signed(t4o.o[i])) + SW'(qd[i]);
      if (!t4o.ok)        pt_nxt[i] = '0;
      else if (sum > PMAX) pt_nxt[i] = W'(PMAX);
      else if (sum < PMIN) pt_nxt[i] = W'(PMIN);
      else                 pt_nxt[i] = W'(sum);
    end
  end

  // stage registers and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r        <= '0;
      c2_r        <= '0;
      c3_r        <= '0;
      c4_r        <= '0;
      c5_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      c1_r        <= c1_nxt;
      c2_r        <= c2_nxt;
      c3_r        <= c3_nxt;
      c4_r        <= c4_nxt;
      c5_r        <= c5_nxt;
      out_valid_r <= t4o.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r <= t4o.ok;
      pt_r  <= pt_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = hit_r;
  assign out_point_x = pt_r[0];
  assign out_point_y = pt_r[1];
  assign out_point_z = pt_r[2];

  // checks
  `RTI_ASSERT_IMP(a_miss_zero, clk, rst_n, out_valid && !out_hit,
    out_point_x == '0 && out_point_y == '0 && out_point_z == '0,
    "miss word carries a nonzero point")
  `RTI_ASSERT_NXT(a_dirz_write, clk, rst_n, psel && penable && pwrite && reg_idx == REG_DIR_Z,
    dir_z_r == $past(pwdata[W-1:0]), "dir_z write not taken")
  `RTI_ASSERT_NXT(a_stall_hold, clk, rst_n, !en, c5_r == $past(c5_r),
    "pipeline moved during a stall")

endmodule

### hdl/rti_mul.sv
// pipelined signed multiplier, four register stages, slices of MUL_CHUNK bits
// depends on rti_pkg
module rti_mul #(
  parameter int AW = 33,
  parameter int BW = 33,
  parameter int TW = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  input  logic [TW-1:0]           tag_i,
  output logic signed [AW+BW-1:0] p,
  output logic [TW-1:0]           tag_o
);
  import rti_pkg::*;

  localparam int CK = MUL_CHUNK;
  localparam int NA = (AW + CK - 1) / CK;
  localparam int NB = (BW + CK - 1) / CK;
  localparam int PW = AW + BW;

  logic [AW-1:0]      a_abs;
  logic [BW-1:0]      b_abs;
  logic [NA*CK-1:0]   am_r;
  logic [NB*CK-1:0]   bm_r;
  logic [2*CK-1:0]    pp_r [NA*NB];
  logic [PW-1:0]      acc_nxt;
  logic [PW-1:0]      acc_r;
  logic [2:0]         sg_r;
  logic signed [PW-1:0] p_r;
  logic [TW-1:0]      tag1_r, tag2_r, tag3_r, tag4_r;

  // magnitudes of the operands
  assign a_abs = a[AW-1] ? AW'(-a) : AW'(a);
  assign b_abs = b[BW-1] ? BW'(-b) : BW'(b);

  // sum of the shifted slice products
  always_comb begin
    acc_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc_nxt = acc_nxt + (PW'(pp_r[i*NB+j]) << (CK * (i + j)));
      end
    end
  end

  // tag line travels with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else if (en) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  // magnitude, slice products, sum, sign
  always_ff @(posedge clk) begin
    if (en) begin
      am_r  <= (NA*CK)'(a_abs);
      bm_r  <= (NB*CK)'(b_abs);
      sg_r[0] <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i*NB+j] <= am_r[i*CK +: CK] * bm_r[j*CK +: CK];
        end
      end
      sg_r[1] <= sg_r[0];
      acc_r   <= acc_nxt;
      sg_r[2] <= sg_r[1];
      p_r     <= sg_r[2] ? $signed(-acc_r) : $signed(acc_r);
    end
  end

  assign p     = p_r;
  assign tag_o = tag4_r;

endmodule

### hdl/rti_div.sv
// pipelined floor divider, one quotient bit per stage, quotient clamped to plus or minus 2^QB
// depends on nothing outside this file
module rti_div #(
  parameter int NW = 134,
  parameter int DW = 102,
  parameter int QB = 34,
  parameter int TW = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic signed [NW-1:0]  n,
  input  logic [DW-1:0]         d,
  input  logic [TW-1:0]         tag_i,
  output logic signed [QB+1:0]  q,
  output logic [TW-1:0]         tag_o
);

  localparam logic signed [QB+1:0] QLIM = (QB+2)'(1) << QB;

  logic [NW-1:0]  ma_r;
  logic [DW-1:0]  da_r;
  logic           nega_r;
  logic [TW-1:0]  taga_r;

  logic [DW-1:0]  rem_r  [QB+1];
  logic [QB-1:0]  qm_r   [QB+1];
  logic [DW-1:0]  dd_r   [QB+1];
  logic [QB:0]    neg_r;
  logic [QB:0]    ovf_r;
  logic [TW-1:0]  tag_r  [QB+1];

  logic [DW-1:0]  rem_nxt [QB];
  logic [QB-1:0]  qm_nxt  [QB];
  logic [DW-1:0]  hi_part;
  logic [QB+1:0]  mag;
  logic signed [QB+1:0] q_r;
  logic [TW-1:0]  tago_r;

  assign hi_part = DW'(ma_r[NW-1:QB]);

  // one restoring step per stage
  always_comb begin
    logic [DW:0] trial;
    logic        ge;
    for (int k = 0; k < QB; k++) begin
      trial      = {rem_r[k], qm_r[k][QB-1]};
      ge         = trial >= {1'b0, dd_r[k]};
      rem_nxt[k] = ge ? DW'(trial - {1'b0, dd_r[k]}) : trial[DW-1:0];
      qm_nxt[k]  = {qm_r[k][QB-2:0], ge};
    end
  end

  assign mag = (QB+2)'(qm_r[QB]);

  // control side: tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taga_r <= '0;
      tago_r <= '0;
      for (int k = 0; k <= QB; k++) tag_r[k] <= '0;
    end else if (en) begin
      taga_r   <= tag_i;
      tag_r[0] <= taga_r;
      for (int k = 0; k < QB; k++) tag_r[k+1] <= tag_r[k];
      tago_r   <= tag_r[QB];
    end
  end

  // data side: magnitude, range check, steps, sign fix
  always_ff @(posedge clk) begin
    if (en) begin
      nega_r   <= n[NW-1];
      ma_r     <= n[NW-1] ? NW'(-n) : NW'(n);
      da_r     <= d;
      ovf_r[0] <= hi_part >= da_r;
      neg_r[0] <= nega_r;
      rem_r[0] <= hi_part;
      qm_r[0]  <= ma_r[QB-1:0];
      dd_r[0]  <= da_r;
      for (int k = 0; k < QB; k++) begin
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
        rem_r[k+1] <= rem_nxt[k];
        qm_r[k+1]  <= qm_nxt[k];
        dd_r[k+1]  <= dd_r[k];
      end
      if (ovf_r[QB]) begin
        q_r <= neg_r[QB] ? -QLIM : QLIM;
      end else if (neg_r[QB]) begin
        q_r <= (rem_r[QB] != '0) ? $signed(~mag) : $signed(-mag);
      end else begin
        q_r <= $signed(mag);
      end
    end
  end

  assign q     = q_r;
  assign tag_o = tago_r;

endmodule
